[src/cfrq_pkg.sv]
`timescale 1ns / 1ps

package cfrq_pkg;

    // Ring geometry: QUEUE_DEPTH slots, at most QUEUE_DEPTH-1 commands held.
    localparam int QUEUE_DEPTH = 16;
    localparam int RING_IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = 4;

    // Frame layout.
    localparam int FRAME_LEN = 9;
    localparam int POS_W     = 4;

    localparam logic [POS_W-1:0] POS_START = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_P     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_D     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

    // Character codes used in the frame check and command decode.
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_UP_P  = 8'h50;
    localparam logic [7:0] CHAR_LOW_D = 8'h64;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_FOUR  = 8'h34;
    localparam logic [7:0] PREV_CMD_RESET = 8'hFF;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [7:0]        head;
        logic [FILL_W-1:0] fill_next;
    } ring_status_t;

endpackage

[src/cfrq_ring.sv]
`timescale 1ns / 1ps

module cfrq_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  pop,
    input  logic [7:0]            push_byte,
    output cfrq_pkg::ring_status_t status
);

    localparam int IW = cfrq_pkg::RING_IDX_W;
    localparam logic [IW:0] DEPTH_V = (IW + 1)'(cfrq_pkg::QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(cfrq_pkg::QUEUE_DEPTH - 1);

    logic [7:0]    ring_mem [cfrq_pkg::QUEUE_DEPTH];
    logic [7:0]    head_reg;
    logic [IW-1:0] wr_reg;
    logic [IW-1:0] wr_next;
    logic [IW-1:0] rd_reg;
    logic [IW-1:0] rd_next;
    logic [IW-1:0] wr_inc;
    logic [IW-1:0] rd_inc;
    logic [IW:0]   diff;

    always_comb
    begin
        wr_inc  = (wr_reg == LAST_IDX) ? '0 : wr_reg + IW'(1);
        rd_inc  = (rd_reg == LAST_IDX) ? '0 : rd_reg + IW'(1);
        wr_next = push ? wr_inc : wr_reg;
        rd_next = pop ? rd_inc : rd_reg;
        if (wr_next >= rd_next)
        begin
            diff = {1'b0, wr_next} - {1'b0, rd_next};
        end
        else
        begin
            diff = {1'b0, wr_next} + DEPTH_V - {1'b0, rd_next};
        end
        status.empty     = (wr_reg == rd_reg);
        status.full      = (wr_inc == rd_reg);
        status.head      = head_reg;
        status.fill_next = cfrq_pkg::FILL_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // The head register follows the slot that will be read next; a byte pushed
    // into that very slot is forwarded straight into it.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[wr_reg] <= push_byte;
        end
        if (push && (wr_reg == rd_next))
        begin
            head_reg <= push_byte;
        end
        else
        begin
            head_reg <= ring_mem[rd_next];
        end
    end

endmodule

[src/command_frame_receiver_queue.sv]
`timescale 1ns / 1ps

// Command frame receiver with a command queue.
// Input channel (in_valid / in_stall): each beat carries an operation and
// rx_byte. A byte beat feeds the nine-byte frame assembler; a take beat pops
// the oldest queued command. Frames must read "-1Pd", three free bytes, the
// command byte and a closing '0'; a good frame queues its command unless full.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, carrying the frame flags, the popped command with its mode decode and
// acknowledge flag, and the queue fill left after that beat.
// out_valid rises in the cycle after acceptance. Unless stalled, one beat
// is taken every cycle: all decoding sits between the input ports and the
// result register, and the ring keeps its oldest command in a head register.
// While the receiver stalls, the result register holds and in_stall is high,
// so no further beat is taken until the held result is taken; a result taken
// in the same cycle frees the register for the next beat.
// Reset empties the queue, returns the frame assembler to the first byte and
// sets the last-command register to 0xFF so the first command is
// acknowledged unless it is 0xFF itself.
module command_frame_receiver_queue (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_complete,
    output logic       frame_queued,
    output logic       frame_lost_full,
    output logic       cmd_present,
    output logic [7:0] cmd_byte,
    output logic       mode_set,
    output logic [2:0] motor_mode,
    output logic       ack_send,
    output logic [3:0] queue_fill
);

    logic                         accept;
    logic                         is_byte;
    logic                         is_take;
    logic                         push;
    logic                         pop;
    logic                         last_byte;
    logic                         frame_good;
    cfrq_pkg::ring_status_t       ring_st;

    logic [cfrq_pkg::POS_W-1:0]   pos_reg;
    logic [cfrq_pkg::POS_W-1:0]   pos_next;
    logic                         ok_one_reg;
    logic                         ok_p_reg;
    logic                         ok_d_reg;
    logic [7:0]                   cmd7_reg;
    logic [7:0]                   prev_cmd_reg;

    logic                         out_valid_reg;
    logic                         complete_reg;
    logic                         queued_reg;
    logic                         lost_reg;
    logic                         present_reg;
    logic [7:0]                   cmd_reg;
    logic                         mode_set_reg;
    logic [2:0]                   mode_reg;
    logic                         ack_reg;
    logic [3:0]                   fill_reg;

    logic                         is_digit;
    logic                         differs;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_byte  = accept && (operation == cfrq_pkg::OP_BYTE);
    assign is_take  = accept && (operation == cfrq_pkg::OP_TAKE);

    // The first byte is only kept when it is a dash; later positions always
    // advance, so the dash check of the final frame is already implied.
    assign last_byte  = is_byte && (pos_reg == cfrq_pkg::POS_LAST);
    assign frame_good = ok_one_reg && ok_p_reg && ok_d_reg
                        && (rx_byte == cfrq_pkg::CHAR_ZERO);
    assign push       = last_byte && frame_good && !ring_st.full;
    assign pop        = is_take && !ring_st.empty;

    assign is_digit = (ring_st.head >= cfrq_pkg::CHAR_ZERO)
                      && (ring_st.head <= cfrq_pkg::CHAR_FOUR);
    assign differs  = (ring_st.head != prev_cmd_reg);

    always_comb
    begin
        pos_next = pos_reg;
        if (is_byte)
        begin
            if (pos_reg == cfrq_pkg::POS_START)
            begin
                pos_next = (rx_byte == cfrq_pkg::CHAR_DASH) ? cfrq_pkg::POS_ONE
                                                            : cfrq_pkg::POS_START;
            end
            else if (pos_reg == cfrq_pkg::POS_LAST)
            begin
                pos_next = cfrq_pkg::POS_START;
            end
            else
            begin
                pos_next = pos_reg + cfrq_pkg::POS_W'(1);
            end
        end
    end

    cfrq_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .push_byte (cmd7_reg),
        .status    (ring_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= cfrq_pkg::POS_START;
            prev_cmd_reg  <= cfrq_pkg::PREV_CMD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (pop && differs)
            begin
                prev_cmd_reg <= ring_st.head;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame field checks, captured as each byte arrives.
    always_ff @(posedge clk)
    begin
        if (is_byte)
        begin
            if (pos_reg == cfrq_pkg::POS_ONE)
            begin
                ok_one_reg <= (rx_byte == cfrq_pkg::CHAR_ONE);
            end
            if (pos_reg == cfrq_pkg::POS_P)
            begin
                ok_p_reg <= (rx_byte == cfrq_pkg::CHAR_UP_P);
            end
            if (pos_reg == cfrq_pkg::POS_D)
            begin
                ok_d_reg <= (rx_byte == cfrq_pkg::CHAR_LOW_D);
            end
            if (pos_reg == cfrq_pkg::POS_CMD)
            begin
                cmd7_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            complete_reg <= last_byte;
            queued_reg   <= push;
            lost_reg     <= last_byte && frame_good && ring_st.full;
            present_reg  <= pop;
            cmd_reg      <= pop ? ring_st.head : 8'h00;
            mode_set_reg <= pop && is_digit;
            mode_reg     <= (pop && is_digit) ? 3'(ring_st.head - cfrq_pkg::CHAR_ZERO)
                                              : 3'd0;
            ack_reg      <= pop && differs;
            fill_reg     <= ring_st.fill_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_complete  = complete_reg;
    assign frame_queued    = queued_reg;
    assign frame_lost_full = lost_reg;
    assign cmd_present     = present_reg;
    assign cmd_byte        = cmd_reg;
    assign mode_set        = mode_set_reg;
    assign motor_mode      = mode_reg;
    assign ack_send        = ack_reg;
    assign queue_fill      = fill_reg;

endmodule
